// ----- design/teq_pkg.sv -----
// shared constants, types and helpers of the timed event queue
package teq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int DATA_WIDTH  = 64;

   localparam int IDX_W      = $clog2(QUEUE_DEPTH);
   localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int TIME_W     = 32;
   localparam int PAYLOAD_W  = 64;
   localparam int DELAY_W    = 16;
   localparam int FCOUNT_W   = 5;

   typedef enum logic [1:0] {
      KIND_ADD   = 2'd0,
      KIND_FIRED = 2'd1,
      KIND_DONE  = 2'd2
   } kind_type;

   typedef enum logic {
      ACTION_TICK = 1'b0,
      ACTION_ADD  = 1'b1
   } action_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD,
      ST_ADD_CMP,
      ST_ACK_YES,
      ST_ACK_NO,
      ST_TICK_RD,
      ST_TICK_CHK,
      ST_TICK_DONE
   } state_type;

   typedef struct packed {
      logic     capture;
      logic     rd_en;
      logic     rd_head;
      logic     wr_new;
      logic     wr_shift;
      logic     pop;
      logic     advance;
      logic     load;
      kind_type kind;
      logic     accepted;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic occ_zero;
      logic walk_zero;
      logic less;
      logic due;
      logic can_load;
   } status_type;

   // ring position to slot, head plus offset stays below twice the depth
   function automatic logic [IDX_W-1:0] slot_of(logic [IDX_W-1:0] head,
                                                logic [CNT_W-1:0] pos);
      logic [CNT_W:0] sum;
      sum = {{(CNT_W + 1 - IDX_W){1'b0}}, head} + {1'b0, pos};
      if (sum >= (CNT_W + 1)'(QUEUE_DEPTH)) begin
         sum = sum - (CNT_W + 1)'(QUEUE_DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

endpackage

// ----- design/teq_if.sv -----
// request and response channel interfaces of the timed event queue
interface teq_req_if;
   logic                                valid;
   logic                                ready;
   logic                                action;
   logic [teq_pkg::PAYLOAD_W-1:0]       payload;
   logic signed [teq_pkg::DELAY_W-1:0]  delay;

   modport source (output valid, output action, output payload, output delay, input ready);
   modport sink   (input valid, input action, input payload, input delay, output ready);
endinterface

interface teq_rsp_if;
   logic                              valid;
   logic                              ready;
   teq_pkg::kind_type                 kind;
   logic                              accepted;
   logic [teq_pkg::PAYLOAD_W-1:0]     event_data;
   logic [teq_pkg::FCOUNT_W-1:0]      fired_count;
   logic                              last;

   modport source (output valid, output kind, output accepted, output event_data,
                   output fired_count, output last, input ready);
   modport sink   (input valid, input kind, input accepted, input event_data,
                   input fired_count, input last, output ready);
endinterface

// ----- design/timed_event_queue.sv -----
// Timed event queue: up to QUEUE_DEPTH events held in a ring buffer sorted by 32-bit
// timestamp (timer plus signed delay, wrapping), equal times kept in arrival order. An add
// transaction answers with one acknowledge (accepted low when full); a tick transaction
// answers with one fired result per due head entry, then a closing result with the count,
// and advances the timer. Requests are taken one at a time. An add walks back from the tail,
// reading and comparing each entry and moving each later one one place back, before the new
// entry is written through the single write port; a tick reads and checks the head entry
// for each event it fires. The next request is taken in the cycle after the last response
// is loaded. Each response sits in an output register, so a stalled consumer holds the
// block only when it must deliver the next result.
module timed_event_queue (
   input  logic      clock,
   input  logic      reset,
   teq_req_if.sink   req,
   teq_rsp_if.source rsp
);
   import teq_pkg::*;

   cmd_type    cmd;
   status_type status;

   teq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req.valid),
      .req_action (req.action),
      .req_ready  (req.ready),
      .status     (status),
      .cmd        (cmd)
   );

   teq_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_payload     (req.payload),
      .req_delay       (req.delay),
      .rsp_valid       (rsp.valid),
      .rsp_ready       (rsp.ready),
      .rsp_kind        (rsp.kind),
      .rsp_accepted    (rsp.accepted),
      .rsp_event_data  (rsp.event_data),
      .rsp_fired_count (rsp.fired_count),
      .rsp_last        (rsp.last)
   );

endmodule

// ----- design/teq_ctrl.sv -----
// controller state machine of the timed event queue
module teq_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_action,
   output logic                req_ready,
   input  teq_pkg::status_type status,
   output teq_pkg::cmd_type    cmd
);
   import teq_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.kind  = KIND_ADD;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = (req_action == ACTION_ADD) ? ST_ADD : ST_TICK_RD;
            end
         end
         ST_ADD: begin
            priority if (status.full) begin
               state_in = ST_ACK_NO;
            end else if (status.walk_zero) begin
               cmd.wr_new = 1'b1;
               state_in   = ST_ACK_YES;
            end else begin
               cmd.rd_en = 1'b1;
               state_in  = ST_ADD_CMP;
            end
         end
         ST_ADD_CMP: begin
            // move the later entry one place back, or drop the new one in
            if (status.less) begin
               cmd.wr_shift = 1'b1;
               state_in     = ST_ADD;
            end else begin
               cmd.wr_new = 1'b1;
               state_in   = ST_ACK_YES;
            end
         end
         ST_ACK_YES, ST_ACK_NO: begin
            if (status.can_load) begin
               cmd.load     = 1'b1;
               cmd.kind     = KIND_ADD;
               cmd.accepted = (state_ff == ST_ACK_YES);
               state_in     = ST_IDLE;
            end
         end
         ST_TICK_RD: begin
            if (status.occ_zero) begin
               state_in = ST_TICK_DONE;
            end else begin
               cmd.rd_en   = 1'b1;
               cmd.rd_head = 1'b1;
               state_in    = ST_TICK_CHK;
            end
         end
         ST_TICK_CHK: begin
            priority if (!status.due) begin
               state_in = ST_TICK_DONE;
            end else if (status.can_load) begin
               cmd.load = 1'b1;
               cmd.kind = KIND_FIRED;
               cmd.pop  = 1'b1;
               state_in = ST_TICK_RD;
            end else begin
               state_in = ST_TICK_CHK;
            end
         end
         ST_TICK_DONE: begin
            if (status.can_load) begin
               cmd.load    = 1'b1;
               cmd.kind    = KIND_DONE;
               cmd.advance = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ----- design/teq_datapath.sv -----
// ring buffer stores, queue pointers, timer and response register
module teq_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  teq_pkg::cmd_type                    cmd,
   output teq_pkg::status_type                 status,
   input  logic [teq_pkg::PAYLOAD_W-1:0]       req_payload,
   input  logic signed [teq_pkg::DELAY_W-1:0]  req_delay,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output teq_pkg::kind_type                   rsp_kind,
   output logic                                rsp_accepted,
   output logic [teq_pkg::PAYLOAD_W-1:0]       rsp_event_data,
   output logic [teq_pkg::FCOUNT_W-1:0]        rsp_fired_count,
   output logic                                rsp_last
);
   import teq_pkg::*;

   logic [TIME_W-1:0]     time_mem [QUEUE_DEPTH];
   logic [DATA_WIDTH-1:0] data_mem [QUEUE_DEPTH];

   logic [IDX_W-1:0]      head_ff;
   logic [CNT_W-1:0]      occ_ff;
   logic [TIME_W-1:0]     now_ff;
   logic [CNT_W-1:0]      walk_ff;
   logic [CNT_W-1:0]      count_ff;
   logic [TIME_W-1:0]     new_time_ff;
   logic [DATA_WIDTH-1:0] new_data_ff;
   logic [TIME_W-1:0]     rd_time_ff;
   logic [DATA_WIDTH-1:0] rd_data_ff;

   logic                  rsp_valid_ff;
   kind_type              rsp_kind_ff;
   logic                  rsp_accepted_ff;
   logic [PAYLOAD_W-1:0]  rsp_data_ff;
   logic [FCOUNT_W-1:0]   rsp_count_ff;
   logic                  rsp_last_ff;

   logic [CNT_W-1:0]      walk_prev;
   logic [IDX_W-1:0]      rd_addr;
   logic [IDX_W-1:0]      wr_addr;
   logic [TIME_W-1:0]     delay_ext;

   assign walk_prev = walk_ff - CNT_W'(1);
   assign rd_addr   = cmd.rd_head ? head_ff : slot_of(head_ff, walk_prev);
   assign wr_addr   = slot_of(head_ff, walk_ff);
   assign delay_ext = {{(TIME_W - DELAY_W){req_delay[DELAY_W-1]}}, req_delay};

   assign status.full      = (occ_ff == CNT_W'(QUEUE_DEPTH));
   assign status.occ_zero  = (occ_ff == '0);
   assign status.walk_zero = (walk_ff == '0);
   assign status.less      = (new_time_ff < rd_time_ff);
   assign status.due       = (rd_time_ff <= now_ff);
   assign status.can_load  = !rsp_valid_ff || rsp_ready;

   // single write port: either the new entry or a shifted one
   always_ff @(posedge clock) begin
      if (cmd.wr_new) begin
         time_mem[wr_addr] <= new_time_ff;
         data_mem[wr_addr] <= new_data_ff;
      end else if (cmd.wr_shift) begin
         time_mem[wr_addr] <= rd_time_ff;
         data_mem[wr_addr] <= rd_data_ff;
      end
      if (cmd.rd_en) begin
         rd_time_ff <= time_mem[rd_addr];
         rd_data_ff <= data_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         new_time_ff <= now_ff + delay_ext;
         new_data_ff <= req_payload[DATA_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         occ_ff   <= '0;
         now_ff   <= '0;
         walk_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (cmd.capture) begin
            walk_ff  <= occ_ff;
            count_ff <= '0;
         end
         if (cmd.wr_shift) begin
            walk_ff <= walk_prev;
         end
         if (cmd.wr_new) begin
            occ_ff <= occ_ff + CNT_W'(1);
         end
         if (cmd.pop) begin
            head_ff  <= slot_of(head_ff, CNT_W'(1));
            occ_ff   <= occ_ff - CNT_W'(1);
            count_ff <= count_ff + CNT_W'(1);
         end
         if (cmd.advance) begin
            now_ff <= now_ff + TIME_W'(1);
         end
      end
   end

   // response register, one transaction held while downstream stalls
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rsp_kind_ff     <= cmd.kind;
         rsp_accepted_ff <= cmd.accepted;
         rsp_data_ff     <= (cmd.kind == KIND_FIRED) ? PAYLOAD_W'(rd_data_ff) : '0;
         rsp_count_ff    <= (cmd.kind == KIND_DONE) ? FCOUNT_W'(count_ff) : '0;
         rsp_last_ff     <= (cmd.kind != KIND_FIRED);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_accepted    = rsp_accepted_ff;
   assign rsp_event_data  = rsp_data_ff;
   assign rsp_fired_count = rsp_count_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

// ----- design/teq_checker.sv -----
// port-level checks of the timed event queue and their binding
module teq_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input teq_pkg::kind_type               rsp_kind,
   input logic                            rsp_accepted,
   input logic [teq_pkg::PAYLOAD_W-1:0]   rsp_event_data,
   input logic [teq_pkg::FCOUNT_W-1:0]    rsp_fired_count,
   input logic                            rsp_last
);
   import teq_pkg::*;

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_event_data)
         && $stable(rsp_fired_count))
      else $error("stalled response transaction changed");

   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last == (rsp_kind != KIND_FIRED)))
      else $error("last flag does not match result kind");

   a_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_kind == KIND_ADD || !rsp_accepted)
         && (rsp_kind == KIND_FIRED || rsp_event_data == '0)
         && (rsp_kind == KIND_DONE || rsp_fired_count == '0))
      else $error("response field set for the wrong kind");

endmodule

bind timed_event_queue teq_checker u_teq_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp.valid),
   .rsp_ready       (rsp.ready),
   .rsp_kind        (rsp.kind),
   .rsp_accepted    (rsp.accepted),
   .rsp_event_data  (rsp.event_data),
   .rsp_fired_count (rsp.fired_count),
   .rsp_last        (rsp.last)
);
